// ===== rtl/sida_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_pkg
// shared types and constants for the signed integer to decimal text unit
// ----------------------------------------------------------------------------
package sida_pkg;

   localparam int VALUE_W = 18;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   // operation applied to every digit cell alike
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        serial_bit;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/sida_digit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_digit_cell
// one bcd digit of the shift-and-add-3 chain, also shifts digits out
// ----------------------------------------------------------------------------
module sida_digit_cell (
   input  wire logic                          clock,
   input  wire sida_pkg::cell_op_type         cell_op,
   input  wire logic                          low_carry,
   input  wire logic [sida_pkg::DIGIT_W-1:0]  low_digit,
   output logic      [sida_pkg::DIGIT_W-1:0]  digit,
   output logic                               carry
);

   logic [sida_pkg::DIGIT_W-1:0] digit_ff;
   logic [sida_pkg::DIGIT_W-1:0] digit_in;
   logic [sida_pkg::DIGIT_W-1:0] adjusted;

   // add 3 when the digit would reach ten after doubling
   assign adjusted = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign carry    = adjusted[sida_pkg::DIGIT_W-1];
   assign digit    = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      case (cell_op)
         sida_pkg::CELL_CLEAR:  digit_in = '0;
         sida_pkg::CELL_DABBLE: digit_in = {adjusted[sida_pkg::DIGIT_W-2:0], low_carry};
         sida_pkg::CELL_SHIFT:  digit_in = low_digit;
         default:               digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule
`default_nettype wire

// ===== rtl/sida_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sida_ctrl
// sequencer: takes the value, drives the digit chain, emits the characters
// ----------------------------------------------------------------------------
module sida_ctrl #(
   parameter int MAX_DIGITS = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [sida_pkg::VALUE_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [sida_pkg::CHAR_W-1:0]    rsp_character,
   output logic                                rsp_last,
   output sida_pkg::cell_cmd_type              cell_cmd,
   input  wire logic [sida_pkg::DIGIT_W-1:0]   top_digit,
   input  wire logic                           chain_overflow
);

   function automatic logic [63:0] digit_limit(input int n);
      logic [63:0] acc;
      acc = 64'd1;
      for (int k = 0; k < n; k++) begin
         acc = acc * 64'd10;
      end
      return acc - 64'd1;
   endfunction

   localparam logic [63:0] DIGIT_LIMIT = digit_limit(MAX_DIGITS);
   localparam int BIT_CNT_W = $clog2(sida_pkg::VALUE_W);
   localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(sida_pkg::VALUE_W - 1);
   localparam int DC_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [DC_W-1:0] DIG_FIRST = DC_W'(MAX_DIGITS - 1);

   sida_pkg::state_type state_ff, state_in;

   logic [sida_pkg::VALUE_W-1:0] mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]         bit_cnt_ff, bit_cnt_in;
   logic [DC_W-1:0]              dig_cnt_ff, dig_cnt_in;
   logic                         lead_ff, lead_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sida_pkg::CHAR_W-1:0]  rsp_character_ff, rsp_character_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [sida_pkg::VALUE_W-1:0] value_mag;
   logic [sida_pkg::VALUE_W-1:0] value_sat;
   logic                         accept;
   logic                         out_free;
   logic                         dig_last;
   logic                         skip;
   logic                         emit_go;
   logic                         load_out;

   // magnitude of the two's complement value, limited to the digit count
   assign value_mag = req_value[sida_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;
   assign value_sat = ({46'd0, value_mag} > DIGIT_LIMIT)
                      ? DIGIT_LIMIT[sida_pkg::VALUE_W-1:0] : value_mag;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign dig_last = (dig_cnt_ff == '0);
   assign skip     = (state_ff == sida_pkg::ST_EMIT) && lead_ff
                     && (top_digit == '0) && !dig_last;
   assign emit_go  = (state_ff == sida_pkg::ST_EMIT) && !skip && out_free;
   assign load_out = ((state_ff == sida_pkg::ST_SIGN) && out_free) || emit_go;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sida_pkg::ST_IDLE: if (req_valid) state_in = sida_pkg::ST_CONV;
         sida_pkg::ST_CONV: begin
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = neg_ff ? sida_pkg::ST_SIGN : sida_pkg::ST_EMIT;
            end
         end
         sida_pkg::ST_SIGN: if (out_free) state_in = sida_pkg::ST_EMIT;
         sida_pkg::ST_EMIT: if (emit_go && dig_last) state_in = sida_pkg::ST_IDLE;
         default:           state_in = sida_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall           = 1'b1;
      cell_cmd.op         = sida_pkg::CELL_HOLD;
      cell_cmd.serial_bit = mag_ff[sida_pkg::VALUE_W-1];
      unique case (state_ff)
         sida_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cell_cmd.op = sida_pkg::CELL_CLEAR;
         end
         sida_pkg::ST_CONV: cell_cmd.op = sida_pkg::CELL_DABBLE;
         sida_pkg::ST_SIGN: cell_cmd.op = sida_pkg::CELL_HOLD;
         sida_pkg::ST_EMIT: if (skip || emit_go) cell_cmd.op = sida_pkg::CELL_SHIFT;
         default:           cell_cmd.op = sida_pkg::CELL_HOLD;
      endcase
   end

   // datapath next values
   always_comb begin
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      bit_cnt_in       = bit_cnt_ff;
      dig_cnt_in       = dig_cnt_ff;
      lead_in          = lead_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;

      if (accept) begin
         mag_in     = value_sat;
         neg_in     = req_value[sida_pkg::VALUE_W-1];
         bit_cnt_in = '0;
         dig_cnt_in = DIG_FIRST;
         lead_in    = 1'b1;
      end else if (state_ff == sida_pkg::ST_CONV) begin
         mag_in     = {mag_ff[sida_pkg::VALUE_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
      end

      if (skip || emit_go) begin
         dig_cnt_in = dig_cnt_ff - 1'b1;
      end
      if (emit_go) begin
         lead_in = 1'b0;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         if (state_ff == sida_pkg::ST_SIGN) begin
            rsp_character_in = sida_pkg::CHAR_MINUS;
            rsp_last_in      = 1'b0;
         end else begin
            rsp_character_in = sida_pkg::CHAR_ZERO + {4'd0, top_digit};
            rsp_last_in      = dig_last;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sida_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      neg_ff           <= neg_in;
      bit_cnt_ff       <= bit_cnt_in;
      dig_cnt_ff       <= dig_cnt_in;
      lead_ff          <= lead_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // a fresh item always starts the conversion from bit zero
   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == sida_pkg::ST_CONV) && (bit_cnt_ff == '0))
      else $error("conversion did not start after accept");

   // saturated magnitude always fits the digit chain
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sida_pkg::ST_CONV) |-> !chain_overflow)
      else $error("digit chain overflow");

   // only a minus sign or a decimal digit leaves the block
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_character_ff == sida_pkg::CHAR_MINUS)
         || ((rsp_character_ff >= sida_pkg::CHAR_ZERO)
             && (rsp_character_ff <= sida_pkg::CHAR_NINE)))
      else $error("bad character");

   // the sign never ends the text
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_character_ff == sida_pkg::CHAR_MINUS)) |-> !rsp_last_ff)
      else $error("minus sign flagged last");

   // leading zero skip never reaches the final digit
   a_skip_not_last: assert property (@(posedge clock) disable iff (reset)
      skip |-> !dig_last)
      else $error("final digit skipped");
`endif

endmodule
`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts a signed 18-bit integer to its decimal text, one ascii character
// per item, most significant first, with a last flag on the final character
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  req_     | in        | req_valid/req_stall | req_value (18b signed)
//  rsp_     | out       | rsp_valid/rsp_stall | rsp_character (8b), rsp_last
//
//  an item is taken in ST_IDLE, then its magnitude goes bit-serially through
//  the digit chain by shift-and-add-3, then a minus sign when negative, then
//  the digit positions in turn (leading zeros are dropped without output);
//  an output stall holds the sign and each digit, while with no stall the
//  18-bit serial shift through the chain takes most of the time of an item
//  synchronous active-high reset clears the sequencer and the output valid
//  an output stall holds the character register; the next item can be taken
//  while the final character still waits
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit #(
   parameter int MAX_DIGITS = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [sida_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [sida_pkg::CHAR_W-1:0]    rsp_character,
   output logic                                rsp_last
);

   // command broadcast to every cell each cycle
   sida_pkg::cell_cmd_type cell_cmd;

   // digit chain: index 0 is the ones digit, MAX_DIGITS-1 the most significant
   logic [MAX_DIGITS-1:0][sida_pkg::DIGIT_W-1:0] digit;
   // carry[g] enters cell g; carry[MAX_DIGITS] leaves the top cell
   logic [MAX_DIGITS:0] carry;

   // serial magnitude bit enters the ones digit during conversion
   assign carry[0] = cell_cmd.serial_bit;

   sida_ctrl #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .cell_cmd       (cell_cmd),
      .top_digit      (digit[MAX_DIGITS-1]),
      .chain_overflow (carry[MAX_DIGITS])
   );

   // each cell takes the carry of its lower neighbor while converting, and
   // its lower neighbor's digit while shifting text out at the top
   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
      logic [sida_pkg::DIGIT_W-1:0] low_digit;

      if (g == 0) begin : g_ones
         assign low_digit = '0;
      end else begin : g_upper
         assign low_digit = digit[g-1];
      end

      sida_digit_cell u_cell (
         .clock     (clock),
         .cell_op   (cell_cmd.op),
         .low_carry (carry[g]),
         .low_digit (low_digit),
         .digit     (digit[g]),
         .carry     (carry[g+1])
      );
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb_signed_int_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_unit
// self-checking bench for the signed integer to decimal text unit: a queue of
// values feeds a falling-edge driver, a rising-edge monitor predicts the text
// of every accepted value and compares each character item and its last flag
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_unit;

   localparam int MAX_DIGITS  = 5;
   localparam int DIGIT_LIMIT = 10 ** MAX_DIGITS - 1;
   localparam int VALUE_SPAN  = 1 << sida_pkg::VALUE_W;
   localparam int RANDOM_ITEMS = 370;
   localparam int DRAIN_CYCLES = 60;   // well past the time of one whole item
   localparam int LONG_HOLD    = 200;  // receiver hold-off, in cycles
   localparam int HOLD_SPACING = 160;  // accepted values between hold-offs

   // one expected character item
   typedef struct packed {
      logic [sida_pkg::CHAR_W-1:0] code;
      logic                        last;
   } text_char_type;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [sida_pkg::VALUE_W-1:0] req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [sida_pkg::CHAR_W-1:0]         rsp_character;
   logic                                rsp_last;

   // values waiting to be offered, and characters still owed by the block
   logic [sida_pkg::VALUE_W-1:0] values_to_send[$];
   text_char_type                text_due[$];

   int values_total = 0;
   int values_taken = 0;
   int error_count  = 0;
   logic req_taken  = 1'b0;

   // long receiver hold-off bookkeeping
   int hold_left    = 0;
   int next_hold_at = 40;

   // per-side idling state
   int send_gap     = 0;
   bit send_quiet   = 1'b0;
   int stall_left   = 0;
   bit recv_quiet   = 1'b0;

   signed_int_to_decimal_ascii_unit #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gap length: mostly none or short, now and then long; none in a quiet run
   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet)
         return 0;
      else if (roll < 40)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // expected text of one value: optional minus, then the saturated magnitude
   // without leading zeros, last flag on the final digit
   function automatic void predict_text(input logic [sida_pkg::VALUE_W-1:0] raw);
      int unsigned                 magnitude;
      int                          digit_count;
      logic [sida_pkg::CHAR_W-1:0] digits [MAX_DIGITS];
      if (raw == '0) begin
         text_due.push_back('{code: sida_pkg::CHAR_ZERO, last: 1'b1});
         return;
      end
      magnitude = raw;
      // negative: magnitude of the sign-extended value, so -131072 works too
      if (raw[sida_pkg::VALUE_W-1])
         magnitude = VALUE_SPAN - magnitude;
      if (magnitude > DIGIT_LIMIT)
         magnitude = DIGIT_LIMIT;
      if (raw[sida_pkg::VALUE_W-1])
         text_due.push_back('{code: sida_pkg::CHAR_MINUS, last: 1'b0});
      digit_count = 0;
      while (magnitude > 0 && digit_count < MAX_DIGITS) begin
         digits[digit_count] = sida_pkg::CHAR_W'(magnitude % 10);
         magnitude = magnitude / 10;
         digit_count++;
      end
      while (digit_count > 0) begin
         digit_count--;
         text_due.push_back('{code: sida_pkg::CHAR_ZERO + digits[digit_count],
                              last: (digit_count == 0)});
      end
   endfunction

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic void queue_value(input int value);
      values_to_send.push_back(sida_pkg::VALUE_W'(value));
   endfunction

   // driver: a new value, or a gap, once the current one has been accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (values_to_send.size() > 0) begin
            req_valid <= 1'b1;
            req_value <= values_to_send.pop_front();
            if ($urandom_range(0, 39) == 0)
               send_quiet = !send_quiet;
            send_gap = pick_gap(send_quiet);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: random stretches, forced high during a long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 59) == 0)
            recv_quiet = !recv_quiet;
         if ($urandom_range(0, 2) == 0)
            stall_left = pick_gap(recv_quiet);
      end
   end

   // long hold-off: every so many accepted values the receiver stops for a
   // long stretch so that the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (values_taken >= next_hold_at) begin
         hold_left    <= LONG_HOLD;
         next_hold_at <= next_hold_at + HOLD_SPACING;
      end
   end

   // monitor: predict on every accepted value, check every accepted character
   always @(posedge clock) begin
      text_char_type due;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_text(req_value);
            values_taken <= values_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (text_due.size() == 0) begin
               flag_mismatch($sformatf("character %0d arrived with nothing due",
                                       rsp_character));
            end else begin
               due = text_due.pop_front();
               if (rsp_character !== due.code)
                  flag_mismatch($sformatf("character %0d, expected %0d",
                                          rsp_character, due.code));
               if (rsp_last !== due.last)
                  flag_mismatch($sformatf("last %b on character %0d, expected %b",
                                          rsp_last, rsp_character, due.last));
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int i;
      int mode;
      int width_pick;
      int magnitude;

      // directed: zero, single digits, digit-count boundaries, both 5-digit
      // extremes, saturation on either side, the most negative 18-bit value,
      // interior zeros and every digit value
      queue_value(0);
      queue_value(1);
      queue_value(-1);
      queue_value(9);
      queue_value(-9);
      queue_value(10);
      queue_value(100);
      queue_value(9999);
      queue_value(10000);
      queue_value(-10007);
      queue_value(99999);
      queue_value(-99999);
      queue_value(100000);
      queue_value(-100000);
      queue_value(131071);
      queue_value(-131072);
      queue_value(12345);
      queue_value(-67890);
      queue_value(90909);
      queue_value(70000);
      queue_value(-50505);

      // random: some raw 18-bit patterns, most in range with a chosen length
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         mode = $urandom_range(0, 19);
         if (mode < 6) begin
            queue_value($urandom_range(0, VALUE_SPAN - 1));
         end else if (mode == 6) begin
            queue_value(0);
         end else begin
            width_pick = $urandom_range(1, MAX_DIGITS);
            magnitude  = $urandom_range(10 ** (width_pick - 1), 10 ** width_pick - 1);
            queue_value($urandom_range(0, 1) ? -magnitude : magnitude);
         end
      end
      values_total = values_to_send.size();

      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (values_taken < values_total)
         @(posedge clock);
      while (text_due.size() > 0)
         @(posedge clock);
      // catch any stray character after the last one due
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && text_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #15_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sida_pkg.sv
rtl/sida_digit_cell.sv
rtl/sida_ctrl.sv
rtl/signed_int_to_decimal_ascii_unit.sv
tb/sv/tb_signed_int_to_decimal_ascii_unit.sv
